/* hw/rtl/dpq_pkg.sv */
// Shared types and codes of the double-ended priority queue.
package dpq_pkg;

    // Size of the key store.
    localparam int DPQ_CAPACITY = 128;

    // Widths of the stream fields.
    localparam int KEY_W    = 32;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int HELD_W   = 8;

    // Operation codes carried in the input tuser.
    localparam logic [KIND_W-1:0] KIND_INSERT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TAKE_MAX = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TAKE_MIN = 2'd2;

    // Status codes carried in the output tuser.
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Command broadcast to every cell of a sorted row.
    typedef enum logic [1:0] {
        CMD_NONE   = 2'd0,  // hold
        CMD_INSERT = 2'd1,  // place the key in order, larger entries move right
        CMD_POP    = 2'd2,  // remove the head, every entry moves left
        CMD_DROP   = 2'd3   // remove the last valid entry
    } t_cmd;

    // What a cell shows to its neighbors.
    typedef struct packed {
        logic                    valid;
        logic                    le;    // valid and key not above the broadcast key
        logic signed [KEY_W-1:0] key;
    } t_link;

endpackage

/* hw/rtl/dpq_cell.sv */
// One cell of a sorted row: holds one key and its valid flag.
module dpq_cell
    import dpq_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    input  logic signed [KEY_W-1:0] i_key,
    input  t_link                   i_left,
    input  t_link                   i_right,
    output t_link                   o_self
);

    logic                    r_valid;
    logic signed [KEY_W-1:0] r_key;
    logic                    n_valid;
    logic signed [KEY_W-1:0] n_key;
    logic                    self_le;

    // Sorted order means the cells at or below the key form a prefix of the row.
    assign self_le = r_valid && (r_key <= i_key);

    assign o_self = '{valid: r_valid, le: self_le, key: r_key};

    // Next contents from this cell and its two neighbors.
    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        case (i_cmd)
            CMD_INSERT: begin
                if (!self_le) begin
                    n_valid = r_valid || i_left.valid;
                    n_key   = i_left.le ? i_key : i_left.key;
                end
            end
            CMD_POP: begin
                n_valid = i_right.valid;
                n_key   = i_right.key;
            end
            CMD_DROP: begin
                n_valid = r_valid && i_right.valid;
            end
            default: begin
                n_valid = r_valid;
                n_key   = r_key;
            end
        endcase
    end

    // Valid flag is control state; the key needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

/* hw/rtl/dpq_row.sv */
// A row of cells that keeps its keys sorted in ascending order from cell 0.
module dpq_row
    import dpq_pkg::*;
#(
    parameter int DEPTH = DPQ_CAPACITY
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    input  logic signed [KEY_W-1:0] i_key,
    output logic                    o_head_valid,
    output logic signed [KEY_W-1:0] o_head_key
);

    t_link cell_out   [DEPTH];
    t_link left_link  [DEPTH];
    t_link right_link [DEPTH];

    // The left edge acts as a valid entry below any key; the right edge is empty.
    assign left_link[0]        = '{valid: 1'b1, le: 1'b1, key: '0};
    assign right_link[DEPTH-1] = '{valid: 1'b0, le: 1'b0, key: '0};

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g > 0) begin : g_left
            assign left_link[g] = cell_out[g-1];
        end
        if (g < DEPTH - 1) begin : g_right
            assign right_link[g] = cell_out[g+1];
        end

        dpq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (i_cmd),
            .i_key   (i_key),
            .i_left  (left_link[g]),
            .i_right (right_link[g]),
            .o_self  (cell_out[g])
        );
    end

    // The smallest key always sits in cell 0.
    assign o_head_valid = cell_out[0].valid;
    assign o_head_key   = cell_out[0].key;

endmodule

/* hw/rtl/double_ended_priority_queue.sv */
// Top level of the double-ended priority queue built from two sorted cell rows.
//
//  Port group | Dir | tdata (low bit up)            | tuser         | Meaning
//  s_axis     | in  | key_in[31:0]                  | kind[1:0]     | one operation per beat
//  m_axis     | out | key_out[31:0], held[39:32]    | status[1:0]   | one result per beat
//
// One operation is accepted per cycle; its result is in the output register from the
// next cycle. Every cell of both rows updates in the same cycle, so the rate is set
// by the broadcast compare across a row, not by the number of keys held.
// A synchronous active-low reset empties both rows and the output register at once.
// The input is stalled only while a result waits in the output register and the
// downstream side is not ready.
module double_ended_priority_queue
    import dpq_pkg::*;
#(
    parameter int CAPACITY = DPQ_CAPACITY
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [KEY_W-1:0]    s_axis_tdata,   // key_in[31:0]
    input  logic [KIND_W-1:0]   s_axis_tuser,   // kind[1:0]
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [KEY_W+HELD_W-1:0] m_axis_tdata, // key_out[31:0], held[39:32]
    output logic [STATUS_W-1:0] m_axis_tuser    // status[1:0]
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Row A keeps keys ascending; row B keeps inverted keys ascending, so its head
    // is the largest key. Inversion reverses signed order exactly.
    logic                    accept;
    logic [KIND_W-1:0]       kind;
    logic signed [KEY_W-1:0] key_in;
    logic                    full;
    logic                    empty;
    t_cmd                    cmd_a;
    t_cmd                    cmd_b;
    logic signed [KEY_W-1:0] key_b;
    logic                    a_head_valid;
    logic signed [KEY_W-1:0] a_head_key;
    logic                    b_head_valid;
    logic signed [KEY_W-1:0] b_head_key;

    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic signed [KEY_W-1:0] n_res_key;
    logic [STATUS_W-1:0]     n_res_status;

    logic                    r_out_valid;
    logic signed [KEY_W-1:0] r_out_key;
    logic [STATUS_W-1:0]     r_out_status;
    logic [HELD_W-1:0]       r_out_held;

    assign kind   = s_axis_tuser;
    assign key_in = s_axis_tdata;
    assign key_b  = ~key_in;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign full  = (r_count == CNT_W'(CAPACITY));
    assign empty = (r_count == '0);

    // Decode the operation into row commands, result and new count.
    always_comb begin
        cmd_a        = CMD_NONE;
        cmd_b        = CMD_NONE;
        n_count      = r_count;
        n_res_key    = '0;
        n_res_status = ST_DONE;
        case (kind)
            KIND_INSERT: begin
                if (full) begin
                    n_res_status = ST_FULL;
                end else begin
                    cmd_a   = CMD_INSERT;
                    cmd_b   = CMD_INSERT;
                    n_count = r_count + CNT_W'(1);
                end
            end
            KIND_TAKE_MAX: begin
                if (empty) begin
                    n_res_status = ST_EMPTY;
                end else begin
                    cmd_a     = CMD_DROP;
                    cmd_b     = CMD_POP;
                    n_res_key = ~b_head_key;
                    n_count   = r_count - CNT_W'(1);
                end
            end
            KIND_TAKE_MIN: begin
                if (empty) begin
                    n_res_status = ST_EMPTY;
                end else begin
                    cmd_a     = CMD_POP;
                    cmd_b     = CMD_DROP;
                    n_res_key = a_head_key;
                    n_count   = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_res_status = ST_DONE;
            end
        endcase
        if (!accept) begin
            cmd_a = CMD_NONE;
            cmd_b = CMD_NONE;
        end
    end

    dpq_row #(
        .DEPTH (CAPACITY)
    ) u_row_min (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_a),
        .i_key        (key_in),
        .o_head_valid (a_head_valid),
        .o_head_key   (a_head_key)
    );

    dpq_row #(
        .DEPTH (CAPACITY)
    ) u_row_max (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_b),
        .i_key        (key_b),
        .o_head_valid (b_head_valid),
        .o_head_key   (b_head_key)
    );

    // Key count and output handshake state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload is captured with each accepted beat.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_key    <= n_res_key;
            r_out_status <= n_res_status;
            r_out_held   <= HELD_W'(n_count);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_held, r_out_key};
    assign m_axis_tuser  = r_out_status;

    // The count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("key count above capacity");

    // Both row heads are valid exactly when keys are held.
    a_heads_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_head_valid == !empty) && (b_head_valid == !empty))
        else $error("row head valid disagrees with key count");

    // The smallest held key never exceeds the largest.
    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (a_head_key <= ~b_head_key))
        else $error("row heads out of order");

    // A successful insert grows the count by one.
    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && kind == KIND_INSERT && !full) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not add one key");

endmodule

/* verif/double_ended_priority_queue_tb.sv */
// Self-checking testbench of the double-ended priority queue with a key multiset scoreboard.
module double_ended_priority_queue_tb
    import dpq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Kind value that the block treats as no operation.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    // Run limits.
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned PRINT_LIMIT = 40;
    localparam int unsigned DRAIN_CYCLES = 10;

    // Key extremes used by the directed part and the random key picker.
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

    // One expected result beat.
    typedef struct packed {
        logic signed [KEY_W-1:0] key_out;
        logic [STATUS_W-1:0]     status;
        logic [HELD_W-1:0]       held;
    } t_dpq_result;

    // Mirrors the held keys as a multiset and queues the results they imply.
    class t_dpq_tracker;
        logic signed [KEY_W-1:0] held_keys[$];
        t_dpq_result             due_results[$];
        int unsigned             mismatches;

        function new();
            mismatches = 0;
        endfunction

        task report_mismatch(input string what);
            mismatches++;
            if (mismatches <= PRINT_LIMIT) begin
                $display("MISMATCH at %0t: %s", $realtime, what);
            end
        endtask

        // Apply one accepted operation to the mirror and queue its result.
        function void apply_op(input logic [KIND_W-1:0] kind,
                               input logic signed [KEY_W-1:0] key);
            t_dpq_result r;
            int          best;
            r.key_out = '0;
            r.status  = ST_DONE;
            case (kind)
                KIND_INSERT: begin
                    if (held_keys.size() >= DPQ_CAPACITY) begin
                        r.status = ST_FULL;
                    end else begin
                        held_keys.push_back(key);
                    end
                end
                KIND_TAKE_MAX, KIND_TAKE_MIN: begin
                    if (held_keys.size() == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        // Equal keys are indistinguishable, so the first extreme will do.
                        best = 0;
                        for (int i = 1; i < held_keys.size(); i++) begin
                            if (kind == KIND_TAKE_MAX ? (held_keys[i] > held_keys[best])
                                                      : (held_keys[i] < held_keys[best])) begin
                                best = i;
                            end
                        end
                        r.key_out = held_keys[best];
                        held_keys.delete(best);
                    end
                end
                default: begin
                end
            endcase
            r.held = HELD_W'(held_keys.size());
            due_results.push_back(r);
        endfunction

        // Compare one result beat with the oldest expectation.
        task match_result(input logic signed [KEY_W-1:0] key_out,
                          input logic [STATUS_W-1:0] status,
                          input logic [HELD_W-1:0] held);
            t_dpq_result want;
            if (due_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result key_out=%0d status=%0d held=%0d",
                                          key_out, status, held));
            end else begin
                want = due_results.pop_front();
                if (key_out !== want.key_out) begin
                    report_mismatch($sformatf("key_out %0d, expected %0d", key_out,
                                              want.key_out));
                end
                if (status !== want.status) begin
                    report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
                end
                if (held !== want.held) begin
                    report_mismatch($sformatf("held %0d, expected %0d", held, want.held));
                end
            end
        endtask

        function int pending();
            return due_results.size();
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [KEY_W-1:0]        s_axis_tdata;   // key_in[31:0]
    logic [KIND_W-1:0]       s_axis_tuser;   // kind[1:0]
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [KEY_W+HELD_W-1:0] m_axis_tdata;   // key_out[31:0], held[39:32]
    logic [STATUS_W-1:0]     m_axis_tuser;   // status[1:0]

    t_dpq_tracker tracker;
    int unsigned  cycle_count;
    logic         rx_running;

    double_ended_priority_queue dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Beat monitor: results are checked and accepted operations predicted at each edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                tracker.match_result(m_axis_tdata[KEY_W-1:0], m_axis_tuser,
                                     m_axis_tdata[KEY_W+HELD_W-1:KEY_W]);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                tracker.apply_op(s_axis_tuser, s_axis_tdata);
            end
        end
    end

    // Receiver: ready runs of random length, short stalls mostly and a few long ones.
    initial begin
        int unsigned run_len;
        int unsigned stall_len;
        int unsigned pick;
        m_axis_tready = 1'b0;
        wait (rx_running === 1'b1);
        forever begin
            run_len = ($urandom_range(0, 99) < 10) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 30);
            repeat (run_len) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                stall_len = $urandom_range(1, 2);
            end else if (pick < 95) begin
                stall_len = $urandom_range(3, 6);
            end else begin
                stall_len = $urandom_range(10, 40);
            end
            repeat (stall_len) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
            end
        end
    end

    // Sender idle length: mostly none, some short, a few long.
    function automatic int unsigned pick_gap();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            return 0;
        end else if (pick < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Random key: full range, a narrow band that gives duplicates, an extreme, or a small value.
    function automatic logic signed [KEY_W-1:0] pick_key();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            return $urandom;
        end else if (pick < 75) begin
            return $signed($urandom_range(0, 15)) - 8;
        end else if (pick < 90) begin
            case ($urandom_range(0, 3))
                0:       return KEY_MAX;
                1:       return KEY_MIN;
                2:       return KEY_MAX - $urandom_range(0, 3);
                default: return KEY_MIN + $urandom_range(0, 3);
            endcase
        end
        return $urandom_range(0, 1) ? $urandom_range(0, 1000) : -$urandom_range(0, 1000);
    endfunction

    // Random operation kind with a given share of inserts and a rare unused kind.
    function automatic logic [KIND_W-1:0] pick_kind(input int unsigned insert_pct);
        if ($urandom_range(0, 99) < 3) begin
            return KIND_UNUSED;
        end else if ($urandom_range(0, 99) < insert_pct) begin
            return KIND_INSERT;
        end
        return $urandom_range(0, 1) ? KIND_TAKE_MAX : KIND_TAKE_MIN;
    endfunction

    // Idle the input for a number of cycles.
    task automatic idle_input(input int unsigned cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
    endtask

    // Present one operation beat and hold it until it is accepted.
    task automatic send_op(input logic [KIND_W-1:0] kind, input logic signed [KEY_W-1:0] key,
                           input int unsigned gap);
        idle_input(gap);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= key;
        s_axis_tuser  <= kind;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
    endtask

    // Hold off until every predicted result has been seen.
    task automatic wait_drained();
        while (tracker.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Stimulus and end of run.
    initial begin
        logic [KIND_W-1:0]       dir_kind[$];
        logic signed [KEY_W-1:0] dir_key[$];
        int unsigned             phase_len[4];
        int unsigned             phase_ins[4];

        tracker       = new();
        cycle_count   = 0;
        rx_running    = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_INSERT;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n    <= 1'b1;
        rx_running <= 1'b1;

        // Directed part: removals and no-op on empty, extremes, duplicates, draining to empty.
        dir_kind = '{KIND_TAKE_MAX, KIND_TAKE_MIN, KIND_UNUSED,
                     KIND_INSERT, KIND_INSERT, KIND_INSERT, KIND_INSERT, KIND_INSERT,
                     KIND_INSERT, KIND_UNUSED,
                     KIND_TAKE_MAX, KIND_TAKE_MIN, KIND_TAKE_MAX, KIND_TAKE_MIN,
                     KIND_TAKE_MIN, KIND_TAKE_MAX, KIND_TAKE_MAX,
                     KIND_INSERT, KIND_INSERT, KIND_TAKE_MIN, KIND_TAKE_MIN, KIND_TAKE_MIN};
        dir_key  = '{32'sh0, -32'sh1, 32'sh1234_5678,
                     KEY_MAX, KEY_MIN, 32'sh0, -32'sh1, -32'sh1,
                     32'sh1, -32'sh1,
                     -32'sh1, KEY_MAX, 32'sh0, KEY_MIN,
                     32'sh5555_5555, 32'sh2AAA_AAAA, 32'sh0,
                     32'shA5A5_A5A5, 32'sh5A5A_5A5A, -32'sh1, 32'sh0, KEY_MAX};
        foreach (dir_kind[i]) begin
            send_op(dir_kind[i], dir_key[i], pick_gap());
        end
        idle_input(1);
        wait_drained();

        // Random part: fill past full, drain past empty, mixed traffic, fill again.
        phase_len = '{220, 200, 80, 50};
        phase_ins = '{88, 12, 50, 95};
        for (int p = 0; p < 4; p++) begin
            for (int n = 0; n < phase_len[p]; n++) begin
                // The mixed phase runs back to back on the input side.
                send_op(pick_kind(phase_ins[p]), pick_key(), (p == 2) ? 0 : pick_gap());
            end
            idle_input(1);
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.pending() != 0) begin
            tracker.report_mismatch($sformatf("%0d results never arrived", tracker.pending()));
        end
        if (tracker.mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/dpq_pkg.sv
hw/rtl/dpq_cell.sv
hw/rtl/dpq_row.sv
hw/rtl/double_ended_priority_queue.sv
verif/double_ended_priority_queue_tb.sv
